// File: src/laa_pkg.sv
package laa_pkg;

  localparam int ARENA_BYTES_DEF = 131072;
  localparam int MAX_ENTRIES_DEF = 32;

  localparam int SIZE_W   = 24;
  localparam int ADDR_W   = 18;
  localparam int TOTAL_W  = 29;
  localparam int LIVE_W   = 6;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic {
    CS_IDLE,
    CS_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic slot_free;
  } dp_sts_t;

endpackage

// File: src/laa_if.sv
interface laa_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [laa_pkg::SIZE_W-1:0]   request_size;
  logic [laa_pkg::ADDR_W-1:0]   free_address;

  modport source (output valid, kind, request_size, free_address, input ready);
  modport sink   (input valid, kind, request_size, free_address, output ready);
endinterface

interface laa_out_if;
  logic                         valid;
  logic                         ready;
  logic [laa_pkg::STATUS_W-1:0] status;
  logic [laa_pkg::ADDR_W-1:0]   offset;
  logic                         used_fallback;
  logic [laa_pkg::SIZE_W-1:0]   entry_bytes;
  logic [laa_pkg::TOTAL_W-1:0]  current_total;
  logic [laa_pkg::TOTAL_W-1:0]  peak_total;
  logic [laa_pkg::LIVE_W-1:0]   live_entries;

  modport source (output valid, status, offset, used_fallback, entry_bytes,
                  current_total, peak_total, live_entries, input ready);
  modport sink   (input valid, status, offset, used_fallback, entry_bytes,
                  current_total, peak_total, live_entries, output ready);
endinterface

// File: src/laa_ctrl.sv
module laa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  laa_pkg::dp_sts_t  sts,
  output laa_pkg::ctl_cmd_t cmd
);

  laa_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= laa_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      laa_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = laa_pkg::CS_EXEC;
        end
      end
      laa_pkg::CS_EXEC: begin
        if (sts.slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = laa_pkg::CS_IDLE;
        end
      end
      default: state_nxt = laa_pkg::CS_IDLE;
    endcase
  end

endmodule

// File: src/laa_dp.sv
module laa_dp #(
  parameter int ARENA_BYTES = laa_pkg::ARENA_BYTES_DEF,
  parameter int MAX_ENTRIES = laa_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  laa_pkg::ctl_cmd_t             cmd,
  output laa_pkg::dp_sts_t              sts,
  input  logic                          in_kind,
  input  logic [laa_pkg::SIZE_W-1:0]    in_size,
  input  logic [laa_pkg::ADDR_W-1:0]    in_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [laa_pkg::STATUS_W-1:0]  out_status,
  output logic [laa_pkg::ADDR_W-1:0]    out_offset,
  output logic                          out_fallback,
  output logic [laa_pkg::SIZE_W-1:0]    out_bytes,
  output logic [laa_pkg::TOTAL_W-1:0]   out_total,
  output logic [laa_pkg::TOTAL_W-1:0]   out_peak,
  output logic [laa_pkg::LIVE_W-1:0]    out_live
);

  localparam int IW = $clog2(ARENA_BYTES + 1);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int DW = (IW > laa_pkg::SIZE_W) ? IW : laa_pkg::SIZE_W;
  localparam int SW = DW + 1;
  localparam int MW = laa_pkg::SIZE_W + 1;
  localparam int TW = laa_pkg::TOTAL_W;

  logic [MW-1:0] stack_mem [MAX_ENTRIES];
  logic [MW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] count_dec;

  logic                       kind_r;
  logic [laa_pkg::SIZE_W-1:0] size_r;
  logic [laa_pkg::ADDR_W-1:0] addr_r;

  logic [IW-1:0] arena_r, arena_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [TW-1:0] peak_r, peak_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic                        out_valid_r;
  laa_pkg::status_t            status_r, status_nxt;
  logic [laa_pkg::ADDR_W-1:0]  offset_r, offset_nxt;
  logic                        fb_r, fb_nxt;
  logic [laa_pkg::SIZE_W-1:0]  bytes_r, bytes_nxt;

  logic                       full, empty, fits, addr_bad, push;
  logic [SW-1:0]              sum;
  logic [DW-1:0]              expect_off;
  logic [laa_pkg::SIZE_W-1:0] top_size;
  logic                       top_fb;
  logic [TW-1:0]              total_add;

  assign count_dec = count_r - CW'(1);
  assign rd_addr   = count_dec[AW-1:0];
  assign top_size  = rd_data_r[laa_pkg::SIZE_W-1:0];
  assign top_fb    = rd_data_r[laa_pkg::SIZE_W];

  always_ff @(posedge clk) begin
    rd_data_r <= stack_mem[rd_addr];
    if (push) begin
      stack_mem[count_r[AW-1:0]] <= {fb_nxt, size_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      size_r <= in_size;
      addr_r <= in_addr;
    end
  end

  assign full       = (count_r == CW'(MAX_ENTRIES));
  assign empty      = (count_r == '0);
  assign sum        = SW'(arena_r) + SW'(size_r);
  assign fits       = (sum <= SW'(ARENA_BYTES));
  assign expect_off = DW'(arena_r) - DW'(top_size);
  assign addr_bad   = (DW'(addr_r) != expect_off);
  assign total_add  = total_r + TW'(size_r);

  always_comb begin
    arena_nxt  = arena_r;
    total_nxt  = total_r;
    peak_nxt   = peak_r;
    count_nxt  = count_r;
    status_nxt = laa_pkg::ST_OK;
    offset_nxt = '0;
    fb_nxt     = 1'b0;
    bytes_nxt  = '0;
    push       = 1'b0;
    case (kind_r)
      laa_pkg::KIND_ALLOC: begin
        if (full) begin
          status_nxt = laa_pkg::ST_FULL;
        end else begin
          push      = cmd.commit;
          fb_nxt    = !fits;
          bytes_nxt = size_r;
          if (fits) begin
            offset_nxt = laa_pkg::ADDR_W'(arena_r);
            arena_nxt  = sum[IW-1:0];
          end
          count_nxt = count_r + CW'(1);
          total_nxt = total_add;
          peak_nxt  = (total_add > peak_r) ? total_add : peak_r;
        end
      end
      default: begin
        if (empty) begin
          status_nxt = laa_pkg::ST_EMPTY;
        end else if (!top_fb && addr_bad) begin
          status_nxt = laa_pkg::ST_MISMATCH;
        end else begin
          fb_nxt    = top_fb;
          bytes_nxt = top_size;
          if (!top_fb) begin
            arena_nxt = expect_off[IW-1:0];
          end
          count_nxt = count_dec;
          total_nxt = total_r - TW'(top_size);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_r     <= '0;
      total_r     <= '0;
      peak_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      arena_r     <= arena_nxt;
      total_r     <= total_nxt;
      peak_r      <= peak_nxt;
      count_r     <= count_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      offset_r <= offset_nxt;
      fb_r     <= fb_nxt;
      bytes_r  <= bytes_nxt;
    end
  end

  assign sts.slot_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_offset   = offset_r;
  assign out_fallback = fb_r;
  assign out_bytes    = bytes_r;
  assign out_total    = total_r;
  assign out_peak     = peak_r;
  assign out_live     = laa_pkg::LIVE_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above stack depth");

  a_state_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(total_r) && $stable(count_r) && $stable(arena_r))
    else $error("allocator state moved without a commit");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result raised without a commit");

  a_peak_covers_total: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (status_nxt == laa_pkg::ST_OK) && (kind_r == laa_pkg::KIND_ALLOC)
    |=> peak_r >= total_r)
    else $error("peak below running total after allocate");

endmodule

// File: src/lifo_arena_allocator_core.sv
// Flow: a request is captured into the input registers in the idle state; in the
// execute state its result is committed into the output registers once the output
// slot is free. Only one request is in flight: the next request is taken while a
// result waits, but not before the previous one commits.
// Reset: arena index, totals, peak and entry count clear to zero; the entry
// stack memory is not cleared and needs no clearing pass.
module lifo_arena_allocator_core #(
  parameter int ARENA_BYTES = laa_pkg::ARENA_BYTES_DEF,
  parameter int MAX_ENTRIES = laa_pkg::MAX_ENTRIES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  laa_in_if.sink      in_chan,
  laa_out_if.source   out_chan
);

  laa_pkg::ctl_cmd_t cmd;
  laa_pkg::dp_sts_t  sts;

  laa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  laa_dp #(
    .ARENA_BYTES (ARENA_BYTES),
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_kind      (in_chan.kind),
    .in_size      (in_chan.request_size),
    .in_addr      (in_chan.free_address),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_status   (out_chan.status),
    .out_offset   (out_chan.offset),
    .out_fallback (out_chan.used_fallback),
    .out_bytes    (out_chan.entry_bytes),
    .out_total    (out_chan.current_total),
    .out_peak     (out_chan.peak_total),
    .out_live     (out_chan.live_entries)
  );

endmodule

// File: test/lifo_arena_allocator_core_tb.sv
module lifo_arena_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARENA       = laa_pkg::ARENA_BYTES_DEF;
  localparam int DEPTH       = laa_pkg::MAX_ENTRIES_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int SIZE_W      = laa_pkg::SIZE_W;
  localparam int ADDR_W      = laa_pkg::ADDR_W;
  localparam int TOTAL_W     = laa_pkg::TOTAL_W;
  localparam int LIVE_W      = laa_pkg::LIVE_W;

  typedef struct packed {
    laa_pkg::status_t     status;
    logic [ADDR_W-1:0]    offset;
    logic                 on_heap;
    logic [SIZE_W-1:0]    bytes;
    logic [TOTAL_W-1:0]   total;
    logic [TOTAL_W-1:0]   peak;
    logic [LIVE_W-1:0]    live;
  } alloc_result_t;

  logic clk;
  logic rst_n;

  laa_in_if  in_chan();
  laa_out_if out_chan();

  lifo_arena_allocator_core #(
    .ARENA_BYTES(ARENA),
    .MAX_ENTRIES(DEPTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  logic [SIZE_W-1:0]  stack_bytes [DEPTH];
  logic               stack_on_heap [DEPTH];
  int unsigned        arena_top = 0;
  logic [TOTAL_W-1:0] live_total = '0;
  logic [TOTAL_W-1:0] peak_seen = '0;
  int unsigned        live_count = 0;

  alloc_result_t pending_q [$];

  int unsigned errors = 0;
  int unsigned n_results = 0;
  int unsigned n_alloc_ok = 0;
  int unsigned n_heap = 0;
  int unsigned n_free_ok = 0;
  int unsigned n_full = 0;
  int unsigned n_empty = 0;
  int unsigned n_bad_addr = 0;
  int unsigned idle_cycles = 0;
  bit          sender_gaps = 1'b0;
  bit          sink_stalls = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic alloc_result_t predict_request(laa_pkg::kind_t k,
                                                    logic [SIZE_W-1:0] sz,
                                                    logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    int unsigned   top;
    int unsigned   base;
    r = '0;
    if (k == laa_pkg::KIND_ALLOC) begin
      if (live_count >= DEPTH) begin
        r.status = laa_pkg::ST_FULL;
        n_full++;
      end else begin
        r.status = laa_pkg::ST_OK;
        r.bytes  = sz;
        if (arena_top + sz > ARENA) begin
          r.on_heap = 1'b1;
          n_heap++;
        end else begin
          r.offset  = arena_top[ADDR_W-1:0];
          arena_top = arena_top + sz;
        end
        stack_bytes[live_count]   = sz;
        stack_on_heap[live_count] = r.on_heap;
        live_count++;
        live_total = live_total + sz;
        if (live_total > peak_seen) peak_seen = live_total;
        n_alloc_ok++;
      end
    end else if (live_count == 0) begin
      r.status = laa_pkg::ST_EMPTY;
      n_empty++;
    end else begin
      top  = live_count - 1;
      base = arena_top - stack_bytes[top];
      if (!stack_on_heap[top] && (addr != base[ADDR_W-1:0] || base > 32'h3FFFF)) begin
        r.status = laa_pkg::ST_MISMATCH;
        n_bad_addr++;
      end else begin
        if (!stack_on_heap[top]) arena_top = base;
        r.status   = laa_pkg::ST_OK;
        r.on_heap  = stack_on_heap[top];
        r.bytes    = stack_bytes[top];
        live_total = live_total - stack_bytes[top];
        live_count = top;
        n_free_ok++;
      end
    end
    r.total = live_total;
    r.peak  = peak_seen;
    r.live  = live_count[LIVE_W-1:0];
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] top_offset();
    if (live_count == 0) return ADDR_W'($urandom);
    return ADDR_W'(arena_top - stack_bytes[live_count-1]);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned room;
    room = ARENA - arena_top;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SIZE_W'($urandom);
      2:       return SIZE_W'(room);
      3:       return SIZE_W'(room + 1);
      4, 5:    return SIZE_W'($urandom_range(0, 65535));
      default: return SIZE_W'($urandom_range(1, 8192));
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic send_request(laa_pkg::kind_t k, logic [SIZE_W-1:0] sz,
                              logic [ADDR_W-1:0] addr);
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_chan.valid        = 1'b1;
    in_chan.kind         = k;
    in_chan.request_size = sz;
    in_chan.free_address = addr;
    do @(posedge clk); while (!in_chan.ready);
    pending_q.push_back(predict_request(k, sz, addr));
  endtask

  initial begin
    out_chan.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_chan.ready = 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        note_mismatch("result transaction with no request outstanding");
      end else begin
        want = pending_q.pop_front();
        check_field("status", out_chan.status, want.status);
        check_field("offset", out_chan.offset, want.offset);
        check_field("used_fallback", out_chan.used_fallback, want.on_heap);
        check_field("entry_bytes", out_chan.entry_bytes, want.bytes);
        check_field("current_total", out_chan.current_total, want.total);
        check_field("peak_total", out_chan.peak_total, want.peak);
        check_field("live_entries", out_chan.live_entries, want.live);
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic test_empty_free();
    send_request(laa_pkg::KIND_FREE, '0, '0);
    send_request(laa_pkg::KIND_FREE, '1, '1);
  endtask

  task automatic test_zero_size();
    send_request(laa_pkg::KIND_ALLOC, '0, '1);
    send_request(laa_pkg::KIND_FREE, '0, top_offset());
  endtask

  task automatic test_arena_edges();
    send_request(laa_pkg::KIND_ALLOC, SIZE_W'(100), '0);
    send_request(laa_pkg::KIND_ALLOC, SIZE_W'(ARENA - 100), '0);
    send_request(laa_pkg::KIND_ALLOC, '0, '0);
    send_request(laa_pkg::KIND_ALLOC, SIZE_W'(1), '0);
    send_request(laa_pkg::KIND_ALLOC, '1, '0);
    // heap entries: address is not checked
    send_request(laa_pkg::KIND_FREE, '0, 18'h2AAAA);
    send_request(laa_pkg::KIND_FREE, '0, 18'h15555);
    send_request(laa_pkg::KIND_FREE, '0, '0);
    send_request(laa_pkg::KIND_FREE, '0, top_offset());
    send_request(laa_pkg::KIND_FREE, '0, top_offset() + 1'b1);
    send_request(laa_pkg::KIND_FREE, '0, top_offset());
    send_request(laa_pkg::KIND_FREE, '0, top_offset());
    send_request(laa_pkg::KIND_FREE, '0, '0);
    send_request(laa_pkg::KIND_ALLOC, SIZE_W'(ARENA + 1), '0);
    send_request(laa_pkg::KIND_FREE, '0, '0);
  endtask

  task automatic test_stack_full();
    int extra;
    extra = $urandom_range(1, 3);
    while (live_count < DEPTH)
      send_request(laa_pkg::KIND_ALLOC, SIZE_W'($urandom_range(0, 6000)),
                   ADDR_W'($urandom));
    repeat (extra) send_request(laa_pkg::KIND_ALLOC, pick_size(), ADDR_W'($urandom));
    while (live_count > 0)
      send_request(laa_pkg::KIND_FREE, SIZE_W'($urandom),
                   ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom) : top_offset());
  endtask

  task automatic test_random_traffic(int count);
    int                alloc_pct;
    logic [ADDR_W-1:0] addr;
    alloc_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) alloc_pct = $urandom_range(25, 75);
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_request(laa_pkg::KIND_ALLOC, pick_size(), ADDR_W'($urandom));
      end else begin
        case ($urandom_range(0, 19))
          0, 1:    addr = ADDR_W'($urandom);
          2:       addr = top_offset() + 1'b1;
          default: addr = top_offset();
        endcase
        send_request(laa_pkg::KIND_FREE, SIZE_W'($urandom), addr);
      end
    end
  endtask

  initial begin
    in_chan.valid        = 1'b0;
    in_chan.kind         = laa_pkg::KIND_ALLOC;
    in_chan.request_size = '0;
    in_chan.free_address = '0;
    rst_n                = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n       = 1'b1;
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;

    test_empty_free();
    test_zero_size();
    test_arena_edges();
    test_stack_full();
    test_random_traffic(450);
    test_stack_full();

    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_random_traffic(150);

    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("checked %0d results: %0d allocations (%0d on heap), %0d frees",
             n_results, n_alloc_ok, n_heap, n_free_ok);
    $display("error statuses: %0d stack full, %0d empty free, %0d bad free address",
             n_full, n_empty, n_bad_addr);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
